[sv/cppc_pkg.sv]
package cppc_pkg;

  // Fixed-point geometry
  localparam int unsigned AccFrac = 12;
  localparam logic signed [25:0] TiltMax = 26'sd8388607;
  localparam logic signed [25:0] TiltMin = -26'sd8388608;

  // Microcode program geometry
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] StepSum = 4'd8;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_POSITION_GAIN  = 3'd0,
    CFG_VELOCITY_LIMIT = 3'd1,
    CFG_VELOCITY_GAIN  = 3'd2,
    CFG_INTEGRAL_GAIN  = 3'd3,
    CFG_INTEGRAL_LIMIT = 3'd4
  } cfg_idx_e;

  // Input actions
  typedef enum logic {
    ACT_UPDATE = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_e;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_POS,
    OP_CLAMP_V,
    OP_VERR,
    OP_MUL_P,
    OP_PTERM,
    OP_MUL_IG,
    OP_MUL_I,
    OP_ACC,
    OP_SUM
  } uc_op_e;

  typedef struct packed {
    logic               action;
    logic signed [15:0] target_position;
    logic signed [15:0] measured_position;
    logic signed [15:0] measured_velocity;
    logic [15:0]        elapsed_time;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] tilt_command;
    logic               output_saturated;
  } out_word_t;

  typedef struct packed {
    logic [15:0] position_gain;
    logic [14:0] velocity_limit;
    logic [15:0] velocity_gain;
    logic [15:0] integral_gain;
    logic [22:0] integral_limit;
  } cfg_t;

  // Control word: operation, conditional jump on "integration skipped", end of program
  typedef struct packed {
    uc_op_e           op;
    logic             br_skip;
    logic [StepW-1:0] target;
    logic             last;
  } uc_word_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   load;
    logic   clear;
    uc_op_e op;
  } dp_ctl_t;

  // Control store
  function automatic uc_word_t uc_rom(logic [StepW-1:0] step);
    uc_word_t w;
    w = '{op: OP_NOP, br_skip: 1'b0, target: '0, last: 1'b0};
    case (step)
      4'd0: w.op = OP_MUL_POS;
      4'd1: w.op = OP_CLAMP_V;
      4'd2: w.op = OP_VERR;
      4'd3: w.op = OP_MUL_P;
      4'd4: begin
        w.op      = OP_PTERM;
        w.br_skip = 1'b1;
        w.target  = StepSum;
      end
      4'd5: w.op = OP_MUL_IG;
      4'd6: w.op = OP_MUL_I;
      4'd7: w.op = OP_ACC;
      4'd8: begin
        w.op   = OP_SUM;
        w.last = 1'b1;
      end
      default: begin
        w.op   = OP_NOP;
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

[sv/cppc_datapath.sv]
module cppc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cppc_pkg::dp_ctl_t   ctl_i,
  input  cppc_pkg::cfg_t      cfg_i,
  input  cppc_pkg::in_word_t  in_word_i,
  output logic                skip_o,
  output cppc_pkg::out_word_t out_word_o
);

  logic signed [16:0] pos_err_q;
  logic signed [15:0] mv_q;
  logic [15:0]        dt_q;
  logic signed [50:0] prod_q, prod_d;
  logic signed [15:0] wanted_q;
  logic signed [16:0] verr_q;
  logic signed [24:0] pterm_q;
  logic signed [35:0] acc_q;
  cppc_pkg::out_word_t out_q;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl_i.op)
      cppc_pkg::OP_MUL_POS: begin
        mul_a = {{17{pos_err_q[16]}}, pos_err_q};
        mul_b = {1'b0, cfg_i.position_gain};
      end
      cppc_pkg::OP_MUL_P: begin
        mul_a = {{17{verr_q[16]}}, verr_q};
        mul_b = {1'b0, cfg_i.velocity_gain};
      end
      cppc_pkg::OP_MUL_IG: begin
        mul_a = {18'b0, cfg_i.integral_gain};
        mul_b = {1'b0, dt_q};
      end
      cppc_pkg::OP_MUL_I: begin
        mul_a = {1'b0, prod_q[32:0]};
        mul_b = verr_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Wanted velocity clamp
  logic signed [42:0] want_sh, vlim43;
  logic signed [15:0] wanted_d;
  assign want_sh = prod_q[50:8];
  assign vlim43  = {28'b0, cfg_i.velocity_limit};
  always_comb begin
    if (want_sh > vlim43) begin
      wanted_d = {1'b0, cfg_i.velocity_limit};
    end else if (want_sh < -vlim43) begin
      wanted_d = -{1'b0, cfg_i.velocity_limit};
    end else begin
      wanted_d = want_sh[15:0];
    end
  end

  // Integral update with clamp
  logic signed [32:0] inc;
  logic signed [36:0] acc_sum, ilim37;
  logic signed [35:0] acc_d;
  assign inc     = prod_q[48:16];
  assign acc_sum = {acc_q[35], acc_q} + {{4{inc[32]}}, inc};
  assign ilim37  = {2'b0, cfg_i.integral_limit, {cppc_pkg::AccFrac{1'b0}}};
  always_comb begin
    if (acc_sum > ilim37) begin
      acc_d = ilim37[35:0];
    end else if (acc_sum < -ilim37) begin
      acc_d = -ilim37[35:0];
    end else begin
      acc_d = acc_sum[35:0];
    end
  end

  // Tilt sum and saturation
  logic signed [25:0] tilt_sum;
  cppc_pkg::out_word_t out_d;
  assign tilt_sum = {pterm_q[24], pterm_q} + {{2{acc_q[35]}}, acc_q[35:12]};
  always_comb begin
    if (tilt_sum > cppc_pkg::TiltMax) begin
      out_d.tilt_command     = cppc_pkg::TiltMax[23:0];
      out_d.output_saturated = 1'b1;
    end else if (tilt_sum < cppc_pkg::TiltMin) begin
      out_d.tilt_command     = cppc_pkg::TiltMin[23:0];
      out_d.output_saturated = 1'b1;
    end else begin
      out_d.tilt_command     = tilt_sum[23:0];
      out_d.output_saturated = 1'b0;
    end
  end

  // Operand and working registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      pos_err_q <= {in_word_i.target_position[15], in_word_i.target_position}
                 - {in_word_i.measured_position[15], in_word_i.measured_position};
      mv_q      <= in_word_i.measured_velocity;
      dt_q      <= in_word_i.elapsed_time;
    end
    case (ctl_i.op)
      cppc_pkg::OP_MUL_POS, cppc_pkg::OP_MUL_P,
      cppc_pkg::OP_MUL_IG, cppc_pkg::OP_MUL_I: prod_q <= prod_d;
      cppc_pkg::OP_CLAMP_V: wanted_q <= wanted_d;
      cppc_pkg::OP_VERR: verr_q <= {wanted_q[15], wanted_q} - {mv_q[15], mv_q};
      cppc_pkg::OP_PTERM: pterm_q <= prod_q[32:8];
      cppc_pkg::OP_SUM: out_q <= out_d;
      default: ;
    endcase
  end

  // Integral accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (ctl_i.op == cppc_pkg::OP_ACC) begin
      acc_q <= acc_d;
    end
  end

  assign skip_o     = (cfg_i.integral_gain == 16'd0) || (dt_q == 16'd0);
  assign out_word_o = out_q;

endmodule

[sv/cascade_p_pi_controller.sv]
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_ready_o    in_word_i  (cppc_pkg::in_word_t)
// out      output     out_valid_o / out_ready_i  out_word_o (cppc_pkg::out_word_t)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An update word runs a 9-step microprogram on one shared multiplier; steps 5 to 7
// are skipped when integration is off (zero gain or time); no word is accepted meanwhile.
// A clear word zeroes the integral and produces no result.
// The result sits in an output register; the next word is accepted meanwhile and
// its program waits at the final step while that register is still occupied.
// Reset loads the register defaults and zeroes the integral.
module cascade_p_pi_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cppc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cppc_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  cppc_pkg::cfg_t cfg_q;
  logic busy_q, busy_d;
  logic [cppc_pkg::StepW-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  cppc_pkg::uc_word_t uc;
  cppc_pkg::dp_ctl_t  ctl;
  logic in_acc, skip, out_free, stall;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.position_gain  <= 16'd256;
      cfg_q.velocity_limit <= 15'd3200;
      cfg_q.velocity_gain  <= 16'd256;
      cfg_q.integral_gain  <= 16'd0;
      cfg_q.integral_limit <= 23'd7680;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cppc_pkg::CFG_POSITION_GAIN:  cfg_q.position_gain  <= cfg_data_i[15:0];
        cppc_pkg::CFG_VELOCITY_LIMIT: cfg_q.velocity_limit <= cfg_data_i[14:0];
        cppc_pkg::CFG_VELOCITY_GAIN:  cfg_q.velocity_gain  <= cfg_data_i[15:0];
        cppc_pkg::CFG_INTEGRAL_GAIN:  cfg_q.integral_gain  <= cfg_data_i[15:0];
        cppc_pkg::CFG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  // Sequencer: control store lookup, branch and stall
  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign uc         = cppc_pkg::uc_rom(step_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign stall      = busy_q && uc.last && !out_free;

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctl.load    = in_acc && (in_word_i.action == cppc_pkg::ACT_UPDATE);
    ctl.clear   = in_acc && (in_word_i.action == cppc_pkg::ACT_CLEAR);
    ctl.op      = (busy_q && !stall) ? uc.op : cppc_pkg::OP_NOP;
    if (ctl.load) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q && !stall) begin
      if (uc.last) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
      end else if (uc.br_skip && skip) begin
        step_d = uc.target;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  cppc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cfg_i      (cfg_q),
    .in_word_i  (in_word_i),
    .skip_o     (skip),
    .out_word_o (out_word_o)
  );

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // Program counter never runs past the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= cppc_pkg::StepSum))
    else $error("step counter out of program");

  // An update word starts the program, a clear word does not
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load |=> (busy_q && step_q == '0))
    else $error("update did not start program");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clear |=> !busy_q)
    else $error("clear started program");

  // The final step never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == cppc_pkg::OP_SUM) |-> out_free)
    else $error("result register overwritten");

  // Program keeps running until its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !uc.last) |=> busy_q)
    else $error("program ended early");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int ClkPeriod = 10;
  localparam int ResetCycles = 8;
  localparam int SettleCycles = 20;
  localparam int HoldCycles = 400;
  localparam int RandPhases = 12;
  localparam int WordsPerPhase = 125;
  localparam int CycleLimit = 1000000;
  localparam int MaxReports = 10;

  localparam logic [15:0] PosMax = 16'h7fff;
  localparam logic [15:0] PosMin = 16'h8000;
  localparam logic [15:0] TimeMax = 16'hffff;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  cppc_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  cppc_pkg::out_word_t out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [31:0]         cfg_data_i = '0;

  cascade_p_pi_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Shadow copy of the controller: registers and integral
  cppc_pkg::cfg_t loop_cfg = '{position_gain: 16'd256, velocity_limit: 15'd3200,
                               velocity_gain: 16'd256, integral_gain: 16'd0,
                               integral_limit: 23'd7680};
  longint integral_acc = 0;

  cppc_pkg::in_word_t  send_q[$];
  cppc_pkg::out_word_t tilt_q[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        hold_seq = 0;
  bit        in_fire = 1'b0;

  function automatic longint clamp_mag(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Expected tilt for one word; a clear only zeroes the integral
  task automatic run_controller(input cppc_pkg::in_word_t w);
    longint pos_err, wanted, vel_err, p_term, step, tilt;
    cppc_pkg::out_word_t res;
    if (w.action == cppc_pkg::ACT_CLEAR) begin
      integral_acc = 0;
    end else begin
      pos_err = longint'($signed(w.target_position))
              - longint'($signed(w.measured_position));
      wanted = (longint'(loop_cfg.position_gain) * pos_err) >>> 8;
      wanted = clamp_mag(wanted, longint'(loop_cfg.velocity_limit));
      vel_err = wanted - longint'($signed(w.measured_velocity));
      p_term = (longint'(loop_cfg.velocity_gain) * vel_err) >>> 8;
      if (loop_cfg.integral_gain != 0 && w.elapsed_time != 0) begin
        step = (longint'(loop_cfg.integral_gain) * vel_err
                * longint'(w.elapsed_time)) >>> 16;
        integral_acc = clamp_mag(integral_acc + step,
                                 longint'(loop_cfg.integral_limit) <<< cppc_pkg::AccFrac);
      end
      tilt = p_term + (integral_acc >>> cppc_pkg::AccFrac);
      res.output_saturated = 1'b0;
      if (tilt > longint'(cppc_pkg::TiltMax)) begin
        tilt = longint'(cppc_pkg::TiltMax);
        res.output_saturated = 1'b1;
      end else if (tilt < longint'(cppc_pkg::TiltMin)) begin
        tilt = longint'(cppc_pkg::TiltMin);
        res.output_saturated = 1'b1;
      end
      res.tilt_command = tilt[23:0];
      tilt_q.push_back(res);
    end
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      cppc_pkg::CFG_POSITION_GAIN:  loop_cfg.position_gain = data[15:0];
      cppc_pkg::CFG_VELOCITY_LIMIT: loop_cfg.velocity_limit = data[14:0];
      cppc_pkg::CFG_VELOCITY_GAIN:  loop_cfg.velocity_gain = data[15:0];
      cppc_pkg::CFG_INTEGRAL_GAIN:  loop_cfg.integral_gain = data[15:0];
      cppc_pkg::CFG_INTEGRAL_LIMIT: loop_cfg.integral_limit = data[22:0];
      default: ;
    endcase
  endtask

  // Monitor: accepted words feed the shadow model, results are checked
  always @(posedge clk_i) begin
    cppc_pkg::out_word_t want;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) set_reg(cfg_index_i, cfg_data_i);
      if (in_fire) run_controller(in_word_i);
      if (out_valid_o && out_ready_i) begin
        if (tilt_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected result: tilt %0d sat %0b",
                     out_word_o.tilt_command, out_word_o.output_saturated);
        end else begin
          want = tilt_q.pop_front();
          if (want.tilt_command !== out_word_o.tilt_command ||
              want.output_saturated !== out_word_o.output_saturated) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("result mismatch: expected tilt %0d sat %0b, got tilt %0d sat %0b",
                       want.tilt_command, want.output_saturated,
                       out_word_o.tilt_command, out_word_o.output_saturated);
          end
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (send_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_word_i <= send_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall modes switched at random, plus a long hold on request
  int       hold_seen = 0;
  int       hold_left = 0;
  int       stall_mode = 0;
  int       mode_left = 0;
  bit [7:0] stall_pat = 8'b1011_0010;
  always @(negedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: begin
          out_ready_i <= stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
      endcase
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] pg, input logic [31:0] vl,
                           input logic [31:0] vg, input logic [31:0] ig,
                           input logic [31:0] il);
    write_reg(cppc_pkg::CFG_POSITION_GAIN, pg);
    write_reg(cppc_pkg::CFG_VELOCITY_LIMIT, vl);
    write_reg(cppc_pkg::CFG_VELOCITY_GAIN, vg);
    write_reg(cppc_pkg::CFG_INTEGRAL_GAIN, ig);
    write_reg(cppc_pkg::CFG_INTEGRAL_LIMIT, il);
  endtask

  // Wait until every word is sent and answered, then let a clear finish
  task automatic settle_block();
    @(posedge clk_i);
    while (send_q.size() != 0 || in_valid_i || tilt_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic cppc_pkg::in_word_t make_word(cppc_pkg::action_e act, logic [15:0] tgt,
                                                   logic [15:0] meas, logic [15:0] vel,
                                                   logic [15:0] dt);
    cppc_pkg::in_word_t w;
    w.action = act;
    w.target_position = tgt;
    w.measured_position = meas;
    w.measured_velocity = vel;
    w.elapsed_time = dt;
    return w;
  endfunction

  // Mostly small tracking errors so the integral builds up over runs of updates
  function automatic cppc_pkg::in_word_t rand_word();
    cppc_pkg::in_word_t w;
    w.action = ($urandom_range(0, 99) < 5) ? cppc_pkg::ACT_CLEAR : cppc_pkg::ACT_UPDATE;
    w.target_position = 16'($urandom);
    if ($urandom_range(0, 3) == 0)
      w.measured_position = 16'($urandom);
    else
      w.measured_position = w.target_position + 16'($urandom_range(0, 64)) - 16'd32;
    if ($urandom_range(0, 3) == 0)
      w.measured_velocity = 16'($urandom);
    else
      w.measured_velocity = 16'($urandom_range(0, 512)) - 16'd256;
    case ($urandom_range(0, 9))
      0: w.elapsed_time = '0;
      1: w.elapsed_time = TimeMax;
      2, 3, 4: w.elapsed_time = 16'($urandom);
      default: w.elapsed_time = 16'($urandom_range(1, 2000));
    endcase
    return w;
  endfunction

  // Register value with occasional extremes and junk above the field
  function automatic logic [31:0] rand_reg(int width);
    logic [31:0] mask;
    logic [31:0] v;
    mask = ~(32'hffff_ffff << width);
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = mask;
      2: v = $urandom_range(0, 1024);
      default: v = $urandom & mask;
    endcase
    if ($urandom_range(0, 3) == 0) v = v | ($urandom << width);
    return v;
  endfunction

  initial begin
    int p;
    int i;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: integration off, extreme errors, a clear
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, '0, '0, '0, '0));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, PosMax, PosMin, '0, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, PosMin, PosMax, PosMax, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, '0, '0, PosMin, 16'd1000));
    send_q.push_back(make_word(cppc_pkg::ACT_CLEAR, PosMax, PosMin, PosMax, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, 16'd100, 16'd90, 16'd5, 16'd1));
    settle_block();

    // Everything at maximum: saturation both ways, integral toward its clamp
    write_all(32'hffff, 32'h7fff, 32'hffff, 32'hffff, 32'h7f_ffff);
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, PosMax, PosMin, PosMin, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, PosMax, PosMin, PosMin, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, PosMax, PosMin, PosMin, '0));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, PosMin, PosMax, PosMax, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, PosMin, PosMax, PosMax, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_CLEAR, '0, '0, '0, '0));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, '0, '0, '0, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, 16'd5, 16'd3, 16'hfffe, 16'd7));
    settle_block();

    // Zero limits: wanted velocity and integral pinned at zero
    write_all(32'hffff, 32'h0, 32'h100, 32'h1, 32'h0);
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, PosMax, PosMin, 16'd300, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, PosMin, PosMax, 16'hfd00, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, '0, '0, PosMin, TimeMax));
    settle_block();

    // Small integral limit, zero proportional gains: integral clamps quickly
    write_all(32'h0, 32'h7fff, 32'h0, 32'hffff, 32'd100);
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, '0, '0, PosMin, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, '0, '0, PosMin, TimeMax));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, '0, '0, PosMax, 16'd3));
    send_q.push_back(make_word(cppc_pkg::ACT_UPDATE, '0, '0, PosMax, TimeMax));
    settle_block();

    // Random phases, each with its own register setting
    for (p = 0; p < RandPhases; p++) begin
      write_all(rand_reg(16), rand_reg(15), rand_reg(16), rand_reg(16), rand_reg(23));
      if (p % 4 == 1)
        write_reg(3'(cppc_pkg::CFG_INTEGRAL_LIMIT) + 3'($urandom_range(1, 3)), $urandom);
      if (p % 5 == 2) hold_seq++;
      for (i = 0; i < WordsPerPhase; i++) send_q.push_back(rand_word());
      settle_block();
    end

    if (fail_count == 0 && tilt_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
